// ===== hdl/ncrs_pkg.sv =====
// Package for the nested clip rectangle stack.
// Holds the rectangle type, fault codes, controller states and shared constants.
// No dependencies.
package ncrs_pkg;

  // Default number of stack entries.
  localparam int unsigned STACK_DEPTH_DEF = 16;

  // Width of one Q12.4 coordinate.
  localparam int unsigned COORD_W = 16;

  // Coordinate shown on every edge while clipping is off (-1.0 in Q12.4).
  localparam logic signed [COORD_W-1:0] DISABLED_COORD = -16'sd16;

  // One clip rectangle, upper-left and lower-right corners.
  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] bottom;
  } rect_t;

  // Action codes of an input word.
  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_t;

  // Fault codes of a result word.
  typedef enum logic [1:0] {
    FAULT_OK    = 2'd0,
    FAULT_FULL  = 2'd1,
    FAULT_EMPTY = 2'd2
  } fault_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEND
  } state_t;

endpackage

// ===== hdl/ncrs_if.sv =====
// Valid/ready channel interfaces for the nested clip rectangle stack.
// Depends on ncrs_pkg for the coordinate width.

// Input channel: one push or pop per word.
interface ncrs_in_if;
  logic                                       valid;
  logic                                       ready;
  logic                                       action;
  logic signed [ncrs_pkg::COORD_W-1:0]        new_left;
  logic signed [ncrs_pkg::COORD_W-1:0]        new_top;
  logic signed [ncrs_pkg::COORD_W-1:0]        new_right;
  logic signed [ncrs_pkg::COORD_W-1:0]        new_bottom;

  modport source (output valid, action, new_left, new_top, new_right, new_bottom,
                  input ready);
  modport sink   (input valid, action, new_left, new_top, new_right, new_bottom,
                  output ready);
endinterface

// Result channel: the active clip rectangle after each item.
interface ncrs_out_if;
  logic                                       valid;
  logic                                       ready;
  logic                                       clip_enabled;
  logic signed [ncrs_pkg::COORD_W-1:0]        clip_left;
  logic signed [ncrs_pkg::COORD_W-1:0]        clip_top;
  logic signed [ncrs_pkg::COORD_W-1:0]        clip_right;
  logic signed [ncrs_pkg::COORD_W-1:0]        clip_bottom;
  logic [1:0]                                 fault;

  modport source (output valid, clip_enabled, clip_left, clip_top, clip_right,
                  clip_bottom, fault, input ready);
  modport sink   (input valid, clip_enabled, clip_left, clip_top, clip_right,
                  clip_bottom, fault, output ready);
endinterface

// ===== hdl/ncrs_stack_mem.sv =====
// Stack storage: one write port and one read port with registered read data.
// Depends on ncrs_pkg for the rectangle type.
module ncrs_stack_mem #(
  parameter int unsigned STACK_DEPTH = ncrs_pkg::STACK_DEPTH_DEF,
  localparam int unsigned IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_idx,
  input  ncrs_pkg::rect_t      wr_data,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_idx,
  output ncrs_pkg::rect_t      rd_data
);

  ncrs_pkg::rect_t mem [STACK_DEPTH];
  ncrs_pkg::rect_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // Read port, with registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/ncrs_clamp.sv =====
// Clamps a pushed rectangle to the current top rectangle.
// Depends on ncrs_pkg for the rectangle type.
module ncrs_clamp (
  input  logic             has_top,
  input  ncrs_pkg::rect_t  new_rect,
  input  ncrs_pkg::rect_t  top_rect,
  output ncrs_pkg::rect_t  clamped
);

  ncrs_pkg::rect_t lim;

  // Pull each edge inside the enclosing rectangle.
  always_comb begin
    lim.left   = (new_rect.left   < top_rect.left)   ? top_rect.left   : new_rect.left;
    lim.top    = (new_rect.top    < top_rect.top)    ? top_rect.top    : new_rect.top;
    lim.right  = (new_rect.right  > top_rect.right)  ? top_rect.right  : new_rect.right;
    lim.bottom = (new_rect.bottom > top_rect.bottom) ? top_rect.bottom : new_rect.bottom;
  end

  // Keep the upper-left corner no further than the lower-right one.
  // An empty stack passes the corners through untouched.
  always_comb begin
    if (has_top) begin
      clamped.right  = lim.right;
      clamped.bottom = lim.bottom;
      clamped.left   = (lim.left > lim.right)  ? lim.right  : lim.left;
      clamped.top    = (lim.top  > lim.bottom) ? lim.bottom : lim.top;
    end else begin
      clamped = new_rect;
    end
  end

endmodule

// ===== hdl/nested_clip_rect_stack.sv =====
// Top level of the nested clip rectangle stack.
// Depends on ncrs_pkg, ncrs_if, ncrs_stack_mem and ncrs_clamp.
//
// Usage
// The input channel takes one word per item: a push carrying the corners of a
// rectangle, or a pop. The result channel gives one word per item: the active
// clip rectangle, or clipping off with every edge at -1.0, plus a fault code
// for a push dropped on a full stack or a pop of an empty stack.
// The top rectangle is cached in a register; every entry is also kept in a
// synchronous memory. A push clamps against the cached top and writes the new
// entry in the cycle it is accepted. A pop that leaves entries behind reads
// the new top from memory, passing through a read state before the result.
// The result word is registered and valid in the cycle after acceptance;
// a pop that leaves the stack non-empty first passes through the read state.
// One item at a time: no new item is taken until the last result is handed over.
// While the receiver stalls, the result word holds and no input is taken.
// Reset empties the stack at once; the memory needs no clearing pass, since
// only entries below the fill count are ever read.
module nested_clip_rect_stack #(
  parameter int unsigned STACK_DEPTH = ncrs_pkg::STACK_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  ncrs_in_if.sink          in_ch,
  ncrs_out_if.source       out_ch
);

  localparam int unsigned IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

  ncrs_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  ncrs_pkg::rect_t  top_r, top_nxt;
  ncrs_pkg::rect_t  res_rect_r, res_rect_nxt;
  logic             res_en_r, res_en_nxt;
  ncrs_pkg::fault_t res_fault_r, res_fault_nxt;

  ncrs_pkg::rect_t  new_rect;
  ncrs_pkg::rect_t  clamped;
  ncrs_pkg::rect_t  off_rect;
  ncrs_pkg::rect_t  rd_data;
  logic             accept;
  logic             is_pop;
  logic             is_empty;
  logic             is_full;
  logic             wr_en;
  logic             rd_en;
  logic [CNT_W-1:0] rd_cnt;

  assign new_rect = '{left:   in_ch.new_left,   top:    in_ch.new_top,
                      right:  in_ch.new_right,  bottom: in_ch.new_bottom};
  assign off_rect = '{left:   ncrs_pkg::DISABLED_COORD, top:    ncrs_pkg::DISABLED_COORD,
                      right:  ncrs_pkg::DISABLED_COORD, bottom: ncrs_pkg::DISABLED_COORD};

  assign accept   = in_ch.valid && in_ch.ready;
  assign is_pop   = (in_ch.action == ncrs_pkg::ACT_POP);
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == CNT_MAX);
  assign rd_cnt   = count_r - CNT_TWO;

  // Clamp the pushed rectangle against the cached top entry.
  ncrs_clamp u_clamp (
    .has_top  (!is_empty),
    .new_rect (new_rect),
    .top_rect (top_r),
    .clamped  (clamped)
  );

  // Stack storage for every entry.
  ncrs_stack_mem #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_idx  (count_r[IDX_W-1:0]),
    .wr_data (clamped),
    .rd_en   (rd_en),
    .rd_idx  (rd_cnt[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // Next state. Only a pop that starts a memory read waits for the data.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ncrs_pkg::S_IDLE: begin
        if (accept) begin
          if (rd_en) begin
            state_nxt = ncrs_pkg::S_READ;
          end else begin
            state_nxt = ncrs_pkg::S_SEND;
          end
        end
      end
      ncrs_pkg::S_READ: begin
        state_nxt = ncrs_pkg::S_SEND;
      end
      ncrs_pkg::S_SEND: begin
        if (out_ch.ready) begin
          state_nxt = ncrs_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ncrs_pkg::S_IDLE;
      end
    endcase
  end

  // Handshake outputs follow the state.
  always_comb begin
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    unique case (state_r)
      ncrs_pkg::S_IDLE: in_ch.ready  = 1'b1;
      ncrs_pkg::S_READ: ;
      ncrs_pkg::S_SEND: out_ch.valid = 1'b1;
      default: ;
    endcase
  end

  // Stack update and result word.
  always_comb begin
    count_nxt     = count_r;
    top_nxt       = top_r;
    res_rect_nxt  = res_rect_r;
    res_en_nxt    = res_en_r;
    res_fault_nxt = res_fault_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    if (accept) begin
      if (!is_pop) begin
        if (is_full) begin
          // Dropped push: show the current top unchanged.
          res_rect_nxt  = top_r;
          res_en_nxt    = 1'b1;
          res_fault_nxt = ncrs_pkg::FAULT_FULL;
        end else begin
          wr_en         = 1'b1;
          count_nxt     = count_r + CNT_ONE;
          top_nxt       = clamped;
          res_rect_nxt  = clamped;
          res_en_nxt    = 1'b1;
          res_fault_nxt = ncrs_pkg::FAULT_OK;
        end
      end else if (is_empty) begin
        res_rect_nxt  = off_rect;
        res_en_nxt    = 1'b0;
        res_fault_nxt = ncrs_pkg::FAULT_EMPTY;
      end else begin
        count_nxt     = count_r - CNT_ONE;
        res_fault_nxt = ncrs_pkg::FAULT_OK;
        if (count_r == CNT_ONE) begin
          res_rect_nxt = off_rect;
          res_en_nxt   = 1'b0;
        end else begin
          // New top comes back from memory next cycle.
          rd_en      = 1'b1;
          res_en_nxt = 1'b1;
        end
      end
    end else if (state_r == ncrs_pkg::S_READ) begin
      top_nxt      = rd_data;
      res_rect_nxt = rd_data;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ncrs_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    top_r       <= top_nxt;
    res_rect_r  <= res_rect_nxt;
    res_en_r    <= res_en_nxt;
    res_fault_r <= res_fault_nxt;
  end

  assign out_ch.clip_enabled = res_en_r;
  assign out_ch.clip_left    = res_rect_r.left;
  assign out_ch.clip_top     = res_rect_r.top;
  assign out_ch.clip_right   = res_rect_r.right;
  assign out_ch.clip_bottom  = res_rect_r.bottom;
  assign out_ch.fault        = res_fault_r;

  // The fill count never passes the stack depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("stack count beyond depth");

  // A result with clipping off shows -1.0 on every edge.
  a_off_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.clip_enabled) |->
      (out_ch.clip_left == ncrs_pkg::DISABLED_COORD &&
       out_ch.clip_right == ncrs_pkg::DISABLED_COORD &&
       out_ch.clip_top == ncrs_pkg::DISABLED_COORD &&
       out_ch.clip_bottom == ncrs_pkg::DISABLED_COORD))
    else $error("disabled marker malformed");

  // Clipping is on exactly while the stack holds an entry.
  a_enable_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.clip_enabled == (count_r != '0)))
    else $error("clip enable disagrees with stack count");

  // An accepted push that is not dropped grows the stack by one.
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_pop && !is_full) |=> (count_r == $past(count_r) + CNT_ONE))
    else $error("push did not grow the stack");

  // A memory read is always followed by its result word.
  a_read_then_send: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ncrs_pkg::S_READ) |=> (state_r == ncrs_pkg::S_SEND))
    else $error("memory read not followed by result");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for nested_clip_rect_stack: pushes and pops go in, and every result word is
// checked against a behavioural copy of the clip stack kept in a small scoreboard class.
// Depends on ncrs_pkg, ncrs_if and the block's RTL.
module testbench;

  localparam int unsigned DEPTH        = ncrs_pkg::STACK_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_WORDS = 1800;
  localparam int unsigned HOLD_CYCLES  = 250;

  // One result word as seen on the output channel.
  typedef struct {
    logic             enabled;
    ncrs_pkg::rect_t  rect;
    logic [1:0]       fault;
  } clip_word_t;

  // Tracks the clip stack and the result words still owed by the block.
  class clip_stack_tracker;
    ncrs_pkg::rect_t rects [DEPTH];
    int unsigned     fill;
    clip_word_t      pending_clips [$];
    int unsigned     failures;

    function new();
      fill     = 0;
      failures = 0;
    endfunction

    function int unsigned pending();
      return pending_clips.size();
    endfunction

    // Applies one accepted push or pop and queues the clip word it must produce.
    function void note_word(ncrs_pkg::action_t act, ncrs_pkg::rect_t req);
      ncrs_pkg::rect_t nxt;
      ncrs_pkg::rect_t cur;
      clip_word_t      word;
      word.fault = ncrs_pkg::FAULT_OK;
      if (act == ncrs_pkg::ACT_PUSH) begin
        if (fill >= DEPTH) begin
          word.fault = ncrs_pkg::FAULT_FULL;
        end else begin
          nxt = req;
          // A nested rectangle is clamped to the one below it, then kept non-inverted.
          if (fill > 0) begin
            cur = rects[fill - 1];
            if (nxt.left < cur.left) nxt.left = cur.left;
            if (nxt.top < cur.top) nxt.top = cur.top;
            if (nxt.right > cur.right) nxt.right = cur.right;
            if (nxt.bottom > cur.bottom) nxt.bottom = cur.bottom;
            if (nxt.left > nxt.right) nxt.left = nxt.right;
            if (nxt.top > nxt.bottom) nxt.top = nxt.bottom;
          end
          rects[fill] = nxt;
          fill++;
        end
      end else if (fill == 0) begin
        word.fault = ncrs_pkg::FAULT_EMPTY;
      end else begin
        fill--;
      end
      if (fill > 0) begin
        word.enabled = 1'b1;
        word.rect    = rects[fill - 1];
      end else begin
        word.enabled = 1'b0;
        word.rect    = {4{ncrs_pkg::DISABLED_COORD}};
      end
      pending_clips = {pending_clips, word};
    endfunction

    function void mismatch(string field, logic signed [16:0] want, logic signed [16:0] got);
      failures++;
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
    endfunction

    // Compares one result word with the oldest outstanding expectation.
    function void check_word(clip_word_t got);
      clip_word_t want;
      if (pending_clips.size() == 0) begin
        failures++;
        $error("result word arrived with no item outstanding");
        return;
      end
      want = pending_clips.pop_front();
      if (got.enabled !== want.enabled)
        mismatch("clip_enabled", want.enabled, got.enabled);
      if (got.rect.left !== want.rect.left)
        mismatch("clip_left", want.rect.left, got.rect.left);
      if (got.rect.top !== want.rect.top)
        mismatch("clip_top", want.rect.top, got.rect.top);
      if (got.rect.right !== want.rect.right)
        mismatch("clip_right", want.rect.right, got.rect.right);
      if (got.rect.bottom !== want.rect.bottom)
        mismatch("clip_bottom", want.rect.bottom, got.rect.bottom);
      if (got.fault !== want.fault)
        mismatch("fault", want.fault, got.fault);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  bit                no_gaps = 1'b0;
  int unsigned       hold_req = 0;
  int unsigned       cycle_count = 0;
  clip_stack_tracker clips = new();

  ncrs_in_if  in_ch ();
  ncrs_out_if out_ch ();

  nested_clip_rect_stack dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run time budget.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Every accepted input word updates the tracked stack.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      clips.note_word(ncrs_pkg::action_t'(in_ch.action),
                      {in_ch.new_left, in_ch.new_top, in_ch.new_right, in_ch.new_bottom});
  end

  // Result side: checks accepted words and drives ready, with random stalls and one long hold.
  initial begin : result_sink
    int unsigned hold_left;
    clip_word_t  got;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.enabled     = out_ch.clip_enabled;
        got.rect.left   = out_ch.clip_left;
        got.rect.top    = out_ch.clip_top;
        got.rect.right  = out_ch.clip_right;
        got.rect.bottom = out_ch.clip_bottom;
        got.fault       = out_ch.fault;
        clips.check_word(got);
      end
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_gaps || ($urandom_range(99) >= 19);
      end
    end
  end

  // Mostly well-ordered rectangles of mixed sizes, some fully random, some inverted.
  function automatic ncrs_pkg::rect_t random_rect();
    ncrs_pkg::rect_t r;
    int              cx;
    int              cy;
    int              hw;
    int              hh;
    int unsigned     pick;
    pick = $urandom_range(9);
    if (pick < 4) begin
      r = {$urandom, $urandom};
    end else begin
      cx = int'($urandom_range(32000)) - 16000;
      cy = int'($urandom_range(32000)) - 16000;
      hw = int'($urandom_range(1, (pick < 7) ? 16000 : 500));
      hh = int'($urandom_range(1, (pick < 7) ? 16000 : 500));
      if (pick == 9) begin
        hw = -hw;
        hh = -hh;
      end
      r.left   = 16'(cx - hw);
      r.right  = 16'(cx + hw);
      r.top    = 16'(cy - hh);
      r.bottom = 16'(cy + hh);
    end
    return r;
  endfunction

  // Offers one word, with an occasional gap first, and returns once it is accepted.
  task automatic offer_word(ncrs_pkg::action_t act, ncrs_pkg::rect_t r);
    if (!no_gaps && $urandom_range(99) < 19) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.new_left   <= r.left;
    in_ch.new_top    <= r.top;
    in_ch.new_right  <= r.right;
    in_ch.new_bottom <= r.bottom;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stops offering until every outstanding result word has come back.
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (clips.pending() != 0);
  endtask

  initial begin : stimulus
    int unsigned push_pct;
    int unsigned n;
    push_pct = 50;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.action     <= ncrs_pkg::ACT_PUSH;
    in_ch.new_left   <= '0;
    in_ch.new_top    <= '0;
    in_ch.new_right  <= '0;
    in_ch.new_bottom <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Pop of an empty stack, then an inverted rectangle taken as given.
    offer_word(ncrs_pkg::ACT_POP, random_rect());
    offer_word(ncrs_pkg::ACT_PUSH, {16'sd100, 16'sd200, -16'sd50, -16'sd300});
    // Nested push that is clamped and then has its left and top edges limited to its right and bottom.
    offer_word(ncrs_pkg::ACT_PUSH, {-16'sd400, 16'sd150, 16'sd900, 16'sd250});
    offer_word(ncrs_pkg::ACT_POP, random_rect());
    offer_word(ncrs_pkg::ACT_POP, random_rect());
    // Extreme coordinates, first as the whole plane, then inverted inside it.
    offer_word(ncrs_pkg::ACT_PUSH, {16'h8000, 16'h8000, 16'h7fff, 16'h7fff});
    offer_word(ncrs_pkg::ACT_PUSH, {16'h7fff, 16'h7fff, 16'h8000, 16'h8000});
    // Fill the stack, then push onto a full stack twice.
    repeat (DEPTH - 2) offer_word(ncrs_pkg::ACT_PUSH, random_rect());
    offer_word(ncrs_pkg::ACT_PUSH, random_rect());
    offer_word(ncrs_pkg::ACT_PUSH, {16'h8000, 16'h8000, 16'h7fff, 16'h7fff});
    offer_word(ncrs_pkg::ACT_POP, random_rect());
    offer_word(ncrs_pkg::ACT_POP, random_rect());

    // Random phase: the push bias changes now and then so the stack roams from empty to full.
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 60 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 25;
          1:       push_pct = 55;
          default: push_pct = 80;
        endcase
      end
      if (n == 400)
        hold_req = HOLD_CYCLES;
      if (n == 900)
        wait_for_results();
      no_gaps = (n >= 1200 && n < 1500);
      if ($urandom_range(99) < push_pct)
        offer_word(ncrs_pkg::ACT_PUSH, random_rect());
      else
        offer_word(ncrs_pkg::ACT_POP, random_rect());
    end

    wait_for_results();
    repeat (10) @(posedge clk);
    if (clips.failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
